>>> hdl/ffea_pkg.sv
// Shared types, constants and layout tables for the first-fit extent allocator.
// No dependencies; imported by every module of the block except ffea_ram.
package ffea_pkg;

    localparam int MAX_EXTENTS_DEF = 64;
    localparam int ADDR_BITS       = 16;
    localparam int EXT_W           = ADDR_BITS + 1;   // extent begin / length
    localparam int NEED_W          = EXT_W + 1;       // size plus field bytes
    localparam int OFF_W           = EXT_W + 3;       // signed reference offset
    localparam int LAY_W           = 3;
    localparam int LAYOUT_COUNT    = 6;
    localparam int CMD_W           = 2;
    localparam int STAT_W          = 2;
    localparam int FB_W            = 4;
    localparam int CFG_W           = 17;
    localparam int IN_DATA_W       = 72;
    localparam int OUT_DATA_W      = 32;
    localparam int SHORT_BITS      = 14;              // a 2-byte field holds 14 signed bits
    localparam logic [FB_W-1:0] FB_NONE  = 4'd0;
    localparam logic [FB_W-1:0] FB_SHORT = 4'd2;
    localparam logic [FB_W-1:0] FB_LONG  = 4'd8;
    localparam logic [EXT_W-1:0] ARENA_LIMIT = EXT_W'(1) << ADDR_BITS;

    typedef enum logic [CMD_W-1:0] {
        CMD_ALLOC     = 2'd0,
        CMD_FREE      = 2'd1,
        CMD_REF_ALLOC = 2'd2,
        CMD_RSVD      = 2'd3
    } t_cmd;

    typedef enum logic [STAT_W-1:0] {
        ST_OK      = 2'd0,
        ST_NO_MEM  = 2'd1,
        ST_INVALID = 2'd2,
        ST_OOB     = 2'd3
    } t_status;

    typedef enum logic [3:0] {
        W_NONE = 4'd0,
        W_INIT = 4'd1,
        W_TAKE = 4'd2,
        W_DOWN = 4'd3,
        W_UP   = 4'd4,
        W_BOTH = 4'd5,
        W_PREV = 4'd6,
        W_NEXT = 4'd7,
        W_NEW  = 4'd8
    } t_wsel;

    typedef struct packed {
        logic    init;
        logic    accept;
        logic    idx_inc;
        logic    idx_dec;
        logic    idx_zero;
        logic    idx_from_cnt;
        logic    lay_inc;
        logic    save_prev;
        logic    save_next;
        logic    set_pos;
        logic    cnt_inc;
        logic    cnt_dec;
        logic    rd_dec;
        logic    grant;
        t_wsel   wsel;
        logic    set_status;
        t_status status;
        logic    out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic    at_end;
        logic    hit;
        logic    take_empty;
        logic    last_lay;
        logic    quick;
        t_status quick_status;
        logic    is_free;
        logic    is_ref;
        logic    overlap;
        logic    mprev;
        logic    mnext;
        logic    full;
        logic    at_pos;
    } t_dp_stat;

    // layouts in trial order: (2,0) (2,2) (8,0) (2,8) (8,2) (8,8)
    function automatic logic [FB_W-1:0] lay_lhs(input logic [LAY_W-1:0] lay);
        case (lay)
            3'd0, 3'd1, 3'd3: lay_lhs = FB_SHORT;
            3'd2, 3'd4, 3'd5: lay_lhs = FB_LONG;
            default:          lay_lhs = FB_LONG;
        endcase
    endfunction

    function automatic logic [FB_W-1:0] lay_rhs(input logic [LAY_W-1:0] lay);
        case (lay)
            3'd0, 3'd2: lay_rhs = FB_NONE;
            3'd1, 3'd4: lay_rhs = FB_SHORT;
            3'd3, 3'd5: lay_rhs = FB_LONG;
            default:    lay_rhs = FB_LONG;
        endcase
    endfunction

endpackage

>>> hdl/ffea_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ffea_ram #(
    parameter int WIDTH = 34,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

>>> hdl/ffea_ctrl.sv
// Sequencing state machine of the extent allocator.
// Depends on ffea_pkg; drives ffea_dp through t_dp_cmd.
module ffea_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic              i_out_ready,
    output logic              o_out_valid,
    input  logic              i_cfg_we,
    input  ffea_pkg::t_dp_stat i_stat,
    output ffea_pkg::t_dp_cmd  o_cmd
);
    import ffea_pkg::*;

    typedef enum logic [10:0] {
        S_INIT    = 11'b000_0000_0001,
        S_IDLE    = 11'b000_0000_0010,
        S_DECIDE  = 11'b000_0000_0100,
        S_SCAN_RD = 11'b000_0000_1000,
        S_SCAN_EV = 11'b000_0001_0000,
        S_FREE    = 11'b000_0010_0000,
        S_SHDN_RD = 11'b000_0100_0000,
        S_SHDN_EV = 11'b000_1000_0000,
        S_SHUP_RD = 11'b001_0000_0000,
        S_SHUP_EV = 11'b010_0000_0000,
        S_FINISH  = 11'b100_0000_0000
    } t_state;

    t_state  r_state, n_state;
    logic    r_out_valid, n_out_valid;
    t_dp_cmd c;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_cmd       = c;

    always_comb begin
        c       = '0;
        c.wsel  = W_NONE;
        c.status = ST_OK;
        n_state = r_state;
        case (r_state)
            S_INIT: begin
                c.init  = 1'b1;
                c.wsel  = W_INIT;
                n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    c.accept = 1'b1;
                    n_state  = S_DECIDE;
                end
            end
            S_DECIDE: begin
                if (i_stat.quick) begin
                    c.set_status = 1'b1;
                    c.status     = i_stat.quick_status;
                    n_state      = S_FINISH;
                end else begin
                    n_state = S_SCAN_RD;
                end
            end
            S_SCAN_RD: begin
                if (!i_stat.at_end) begin
                    n_state = S_SCAN_EV;
                end else if (i_stat.is_free) begin
                    n_state = S_FREE;
                end else if (i_stat.is_ref && !i_stat.last_lay) begin
                    c.lay_inc  = 1'b1;
                    c.idx_zero = 1'b1;
                end else begin
                    c.set_status = 1'b1;
                    c.status     = ST_NO_MEM;
                    n_state      = S_FINISH;
                end
            end
            S_SCAN_EV: begin
                if (i_stat.hit && i_stat.is_free) begin
                    c.save_next = 1'b1;
                    n_state     = S_FREE;
                end else if (i_stat.hit) begin
                    c.grant = 1'b1;
                    if (i_stat.take_empty) begin
                        c.idx_inc = 1'b1;
                        n_state   = S_SHDN_RD;
                    end else begin
                        c.wsel  = W_TAKE;
                        n_state = S_FINISH;
                    end
                end else begin
                    c.save_prev = i_stat.is_free;
                    c.idx_inc   = 1'b1;
                    n_state     = S_SCAN_RD;
                end
            end
            S_FREE: begin
                if (i_stat.overlap) begin
                    c.set_status = 1'b1;
                    c.status     = ST_INVALID;
                    n_state      = S_FINISH;
                end else if (i_stat.mprev && i_stat.mnext) begin
                    c.wsel    = W_BOTH;
                    c.idx_inc = 1'b1;
                    n_state   = S_SHDN_RD;
                end else if (i_stat.mprev) begin
                    c.wsel  = W_PREV;
                    n_state = S_FINISH;
                end else if (i_stat.mnext) begin
                    c.wsel  = W_NEXT;
                    n_state = S_FINISH;
                end else if (i_stat.full) begin
                    c.set_status = 1'b1;
                    c.status     = ST_NO_MEM;
                    n_state      = S_FINISH;
                end else begin
                    c.set_pos      = 1'b1;
                    c.idx_from_cnt = 1'b1;
                    n_state        = S_SHUP_RD;
                end
            end
            S_SHDN_RD: begin
                if (i_stat.at_end) begin
                    c.cnt_dec = 1'b1;
                    n_state   = S_FINISH;
                end else begin
                    n_state = S_SHDN_EV;
                end
            end
            S_SHDN_EV: begin
                c.wsel    = W_DOWN;
                c.idx_inc = 1'b1;
                n_state   = S_SHDN_RD;
            end
            S_SHUP_RD: begin
                if (i_stat.at_pos) begin
                    c.wsel    = W_NEW;
                    c.cnt_inc = 1'b1;
                    n_state   = S_FINISH;
                end else begin
                    c.rd_dec = 1'b1;
                    n_state  = S_SHUP_EV;
                end
            end
            S_SHUP_EV: begin
                c.wsel    = W_UP;
                c.idx_dec = 1'b1;
                n_state   = S_SHUP_RD;
            end
            S_FINISH: begin
                if (!r_out_valid || i_out_ready) begin
                    c.out_load = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_INIT;
            end
        endcase
        if (i_cfg_we) begin
            n_state = S_INIT;
        end
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (c.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end
endmodule

>>> hdl/ffea_dp.sv
// Datapath of the extent allocator: request registers, extent table RAM,
// fit and merge tests, result registers. Depends on ffea_pkg and ffea_ram.
module ffea_dp #(
    parameter int MAX_EXTENTS = ffea_pkg::MAX_EXTENTS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [ffea_pkg::CFG_W-1:0]  i_cfg_data,
    input  ffea_pkg::t_cmd              i_cmd,
    input  logic [ffea_pkg::EXT_W-1:0]  i_size,
    input  logic [ffea_pkg::ADDR_BITS-1:0] i_fstart,
    input  logic                        i_has_lhs,
    input  logic [ffea_pkg::ADDR_BITS-1:0] i_lhs_target,
    input  logic                        i_has_rhs,
    input  logic [ffea_pkg::ADDR_BITS-1:0] i_rhs_target,
    input  ffea_pkg::t_dp_cmd           i_dcmd,
    output ffea_pkg::t_dp_stat          o_stat,
    output ffea_pkg::t_status           o_status,
    output logic [ffea_pkg::ADDR_BITS-1:0] o_alloc_start,
    output logic [ffea_pkg::FB_W-1:0]   o_lhs_bytes,
    output logic [ffea_pkg::FB_W-1:0]   o_rhs_bytes
);
    import ffea_pkg::*;

    localparam int IW = $clog2(MAX_EXTENTS);
    localparam int CW = $clog2(MAX_EXTENTS + 1);
    localparam int RW = 2 * EXT_W;

    logic [EXT_W-1:0]     r_arena;
    logic [CW-1:0]        r_count, r_idx, r_pos;
    logic [LAY_W-1:0]     r_lay;
    t_cmd                 r_cmd;
    logic [EXT_W-1:0]     r_size;
    logic [ADDR_BITS-1:0] r_fstart, r_lt, r_rt;
    logic                 r_hl, r_hr;
    logic [EXT_W-1:0]     r_prev_b, r_prev_l, r_next_b, r_next_l;
    logic                 r_has_prev, r_has_next;
    t_status              r_res_status, r_out_status;
    logic [ADDR_BITS-1:0] r_res_start, r_out_start;
    logic [FB_W-1:0]      r_res_lb, r_res_rb, r_out_lb, r_out_rb;

    logic [RW-1:0]        rdata, wdata;
    logic [CW-1:0]        waddr, raddr, idx_m1;
    logic                 we;
    logic [EXT_W-1:0]     rd_b, rd_l, fstart_x, cfg_arena;
    logic [FB_W-1:0]      lhs_b, rhs_b;
    logic [NEED_W-1:0]    need, lower_tail, free_end;
    logic [OFF_W-1:0]     base, loff, roff;
    logic                 fit_l, fit_r, len_ok, oob;

    ffea_ram #(.WIDTH(RW), .DEPTH(MAX_EXTENTS)) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr[IW-1:0]),
        .i_wdata (wdata),
        .i_raddr (raddr[IW-1:0]),
        .o_rdata (rdata)
    );

    assign rd_b     = rdata[EXT_W-1:0];
    assign rd_l     = rdata[RW-1:EXT_W];
    assign idx_m1   = r_idx - CW'(1);
    assign raddr    = i_dcmd.rd_dec ? idx_m1 : r_idx;
    assign fstart_x = EXT_W'(r_fstart);

    // oversized arena clamps to the address space
    assign cfg_arena = (EXT_W'(i_cfg_data) > ARENA_LIMIT) ? ARENA_LIMIT : EXT_W'(i_cfg_data);

    // fit tests for the entry on the read port
    assign lhs_b  = (r_cmd == CMD_REF_ALLOC) ? lay_lhs(r_lay) : FB_NONE;
    assign rhs_b  = (r_cmd == CMD_REF_ALLOC) ? lay_rhs(r_lay) : FB_NONE;
    assign need   = NEED_W'(r_size) + NEED_W'(lhs_b) + NEED_W'(rhs_b);
    assign len_ok = NEED_W'(rd_l) >= need;
    assign base   = OFF_W'(rd_b) + OFF_W'(r_size);
    assign loff   = OFF_W'(r_lt) - base;
    assign roff   = OFF_W'(r_rt) - base - OFF_W'(lhs_b);
    // a short field fits when the bits above its sign bit are all copies of it
    assign fit_l  = (lhs_b != FB_SHORT) || (&loff[OFF_W-1:SHORT_BITS-1])
                    || (~|loff[OFF_W-1:SHORT_BITS-1]);
    assign fit_r  = (rhs_b == FB_NONE) ? !r_hr
                    : (!r_hr || rhs_b == FB_LONG || (&roff[OFF_W-1:SHORT_BITS-1])
                       || (~|roff[OFF_W-1:SHORT_BITS-1]));

    assign lower_tail = NEED_W'(r_prev_b) + NEED_W'(r_prev_l);
    assign free_end   = NEED_W'(r_fstart) + NEED_W'(r_size);
    assign oob        = (fstart_x >= r_arena) || (r_size > (r_arena - fstart_x));

    always_comb begin
        o_stat            = '0;
        o_stat.at_end     = (r_idx >= r_count);
        o_stat.is_free    = (r_cmd == CMD_FREE);
        o_stat.is_ref     = (r_cmd == CMD_REF_ALLOC);
        o_stat.hit        = (r_cmd == CMD_FREE) ? (rd_b >= fstart_x)
                            : (len_ok && ((r_cmd != CMD_REF_ALLOC) || (fit_l && fit_r)));
        o_stat.take_empty = (NEED_W'(rd_l) == need);
        o_stat.last_lay   = (r_lay == LAY_W'(LAYOUT_COUNT - 1));
        o_stat.overlap    = (r_has_prev && lower_tail > NEED_W'(r_fstart))
                            || (r_has_next && free_end > NEED_W'(r_next_b));
        o_stat.mprev      = r_has_prev && (lower_tail == NEED_W'(r_fstart));
        o_stat.mnext      = r_has_next && (free_end == NEED_W'(r_next_b));
        o_stat.full       = (r_count == CW'(MAX_EXTENTS));
        o_stat.at_pos     = (r_idx == r_pos);
        o_stat.quick        = 1'b0;
        o_stat.quick_status = ST_OK;
        if (r_cmd == CMD_RSVD) begin
            o_stat.quick        = 1'b1;
            o_stat.quick_status = ST_INVALID;
        end else if (r_size == '0) begin
            o_stat.quick = 1'b1;
        end else if (r_cmd == CMD_REF_ALLOC && !r_hl) begin
            o_stat.quick        = 1'b1;
            o_stat.quick_status = ST_INVALID;
        end else if (r_cmd == CMD_FREE && oob) begin
            o_stat.quick        = 1'b1;
            o_stat.quick_status = ST_OOB;
        end
    end

    // table write port; entries pack as {length, begin}
    always_comb begin
        we    = 1'b1;
        waddr = r_idx;
        wdata = rdata;
        case (i_dcmd.wsel)
            W_INIT: begin
                waddr = '0;
                wdata = {r_arena, EXT_W'(0)};
            end
            W_TAKE: wdata = {rd_l - need[EXT_W-1:0], rd_b + need[EXT_W-1:0]};
            W_DOWN: waddr = idx_m1;
            W_UP:   wdata = rdata;
            W_BOTH: begin
                waddr = idx_m1;
                wdata = {r_prev_l + r_size + r_next_l, r_prev_b};
            end
            W_PREV: begin
                waddr = idx_m1;
                wdata = {r_prev_l + r_size, r_prev_b};
            end
            W_NEXT: wdata = {r_next_l + r_size, fstart_x};
            W_NEW:  wdata = {r_size, fstart_x};
            default: we = 1'b0;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_arena    <= ARENA_LIMIT;
            r_count    <= '0;
            r_idx      <= '0;
            r_lay      <= '0;
            r_has_prev <= 1'b0;
            r_has_next <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_arena <= cfg_arena;
            end
            if (i_dcmd.init) begin
                r_count <= CW'(r_arena != '0);
            end else if (i_dcmd.cnt_inc) begin
                r_count <= r_count + CW'(1);
            end else if (i_dcmd.cnt_dec) begin
                r_count <= r_count - CW'(1);
            end
            if (i_dcmd.accept || i_dcmd.idx_zero) begin
                r_idx <= '0;
            end else if (i_dcmd.idx_from_cnt) begin
                r_idx <= r_count;
            end else if (i_dcmd.idx_inc) begin
                r_idx <= r_idx + CW'(1);
            end else if (i_dcmd.idx_dec) begin
                r_idx <= idx_m1;
            end
            if (i_dcmd.accept) begin
                r_lay      <= '0;
                r_has_prev <= 1'b0;
                r_has_next <= 1'b0;
            end else begin
                if (i_dcmd.lay_inc) begin
                    r_lay <= r_lay + LAY_W'(1);
                end
                if (i_dcmd.save_prev) begin
                    r_has_prev <= 1'b1;
                end
                if (i_dcmd.save_next) begin
                    r_has_next <= 1'b1;
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_dcmd.accept) begin
            r_cmd        <= i_cmd;
            r_size       <= i_size;
            r_fstart     <= i_fstart;
            r_hl         <= i_has_lhs;
            r_lt         <= i_lhs_target;
            r_hr         <= i_has_rhs;
            r_rt         <= i_rhs_target;
            r_res_status <= ST_OK;
            r_res_start  <= '0;
            r_res_lb     <= FB_NONE;
            r_res_rb     <= FB_NONE;
        end else begin
            if (i_dcmd.set_status) begin
                r_res_status <= i_dcmd.status;
            end
            if (i_dcmd.grant) begin
                r_res_start <= rd_b[ADDR_BITS-1:0];
                r_res_lb    <= lhs_b;
                r_res_rb    <= rhs_b;
            end
        end
        if (i_dcmd.save_prev) begin
            r_prev_b <= rd_b;
            r_prev_l <= rd_l;
        end
        if (i_dcmd.save_next) begin
            r_next_b <= rd_b;
            r_next_l <= rd_l;
        end
        if (i_dcmd.set_pos) begin
            r_pos <= r_idx;
        end
        if (i_dcmd.out_load) begin
            r_out_status <= r_res_status;
            r_out_start  <= r_res_start;
            r_out_lb     <= r_res_lb;
            r_out_rb     <= r_res_rb;
        end
    end

    assign o_status      = r_out_status;
    assign o_alloc_start = r_out_start;
    assign o_lhs_bytes   = r_out_lb;
    assign o_rhs_bytes   = r_out_rb;
endmodule

>>> hdl/first_fit_extent_allocator_unit.sv
// Top level of the first-fit extent allocator: stream ports, controller, datapath.
// Depends on ffea_pkg, ffea_ctrl, ffea_dp (and ffea_ram below it).
//
// The block keeps an address-sorted table of free extents (up to MAX_EXTENTS) in one
// RAM and serves one request at a time: plain alloc (first fit), alloc with reference
// fields (six field layouts tried in turn, each over the whole table), and free with
// coalescing into its neighbors. Each request returns one result on the master side;
// a result waits in the output register while the next request is already taken.
// Run time is set by the table walk, with a read state and an evaluate state per visited
// entry, for each entry scanned and for each entry moved when an extent is removed or
// inserted; a ref-aware alloc that fails can walk the table six times. Zero-size,
// malformed and out-of-bounds requests go from the decide state straight to the finish
// state. After reset and after each arena_size write the block rebuilds the table in its
// init state and holds s_axis_tready low meanwhile. Write arena_size only while no
// request is open.
module first_fit_extent_allocator_unit #(
    parameter int MAX_EXTENTS = ffea_pkg::MAX_EXTENTS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // request channel
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // [16:0] request_size, [32:17] free_start, [33] has_lhs, [49:34] lhs_target,
    // [50] has_rhs, [66:51] rhs_target, [71:67] zero
    input  logic [ffea_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    // [1:0] cmd
    input  logic [ffea_pkg::CMD_W-1:0]       s_axis_tuser,
    // result channel
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // [1:0] status, [17:2] alloc_start, [21:18] lhs_field_bytes,
    // [25:22] rhs_field_bytes, [31:26] zero
    output logic [ffea_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
    // arena_size register
    input  logic                             i_cfg_we,
    input  logic [ffea_pkg::CFG_W-1:0]       i_cfg_data
);
    import ffea_pkg::*;

    t_dp_cmd              dcmd;
    t_dp_stat             dstat;
    t_status              status;
    logic [ADDR_BITS-1:0] alloc_start;
    logic [FB_W-1:0]      lhs_bytes, rhs_bytes;

    ffea_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_cfg_we    (i_cfg_we),
        .i_stat      (dstat),
        .o_cmd       (dcmd)
    );

    // unpack the request fields straight into the datapath
    ffea_dp #(.MAX_EXTENTS(MAX_EXTENTS)) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_data    (i_cfg_data),
        .i_cmd         (t_cmd'(s_axis_tuser)),
        .i_size        (s_axis_tdata[16:0]),
        .i_fstart      (s_axis_tdata[32:17]),
        .i_has_lhs     (s_axis_tdata[33]),
        .i_lhs_target  (s_axis_tdata[49:34]),
        .i_has_rhs     (s_axis_tdata[50]),
        .i_rhs_target  (s_axis_tdata[66:51]),
        .i_dcmd        (dcmd),
        .o_stat        (dstat),
        .o_status      (status),
        .o_alloc_start (alloc_start),
        .o_lhs_bytes   (lhs_bytes),
        .o_rhs_bytes   (rhs_bytes)
    );

    assign m_axis_tdata = {6'd0, rhs_bytes, lhs_bytes, alloc_start, status};
endmodule

>>> hdl/ffea_chk.sv
// Port-level checker for the extent allocator, bound to the top level.
// Depends on ffea_pkg and first_fit_extent_allocator_unit.
module ffea_chk (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            s_axis_tvalid,
    input logic                            s_axis_tready,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [ffea_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
    import ffea_pkg::*;

    // hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

    // one request in flight: ready drops after every accept
    a_one_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("request accepted while another is open");

    // no result right after reset
    a_rst_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

    // failed requests carry no grant
    a_fail_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[1:0] != ST_OK |-> m_axis_tdata[25:2] == '0)
        else $error("failed request reports a grant");

    // lhs field size is 0, 2 or 8 bytes
    a_field_size: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[21:18] == FB_NONE || m_axis_tdata[21:18] == FB_SHORT
                           || m_axis_tdata[21:18] == FB_LONG))
        else $error("bad lhs field size");
endmodule

bind first_fit_extent_allocator_unit ffea_chk u_ffea_chk (.*);
